@@ hdl/mvpe_pkg.sv @@
// Package for the parenthesized-expression maximum block.
// Holds the token and result payload types, operator codes and the ALU control type.
// No dependencies.
`default_nettype none

package mvpe_pkg;

  // Field widths.
  localparam int DIGIT_W = 4;
  localparam int OP_W    = 2;
  localparam int RES_W   = 52;
  // Exact width of every span value; magnitudes stay below 2^63.
  localparam int VALUE_W = 64;
  localparam int HALF_W  = VALUE_W / 2;
  // One span entry holds the minimum in the upper half and the maximum in the lower half.
  localparam int SPAN_W  = 2 * VALUE_W;

  // Operator codes carried by a token; the unused code decodes as add.
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [OP_W-1:0]    op_after;
    logic               last;
  } token_t;

  typedef struct packed {
    logic signed [RES_W-1:0] max_value;
    logic                    too_long;
  } result_t;

  // Operations of the shared arithmetic unit. A product takes three steps:
  // low by low, then the two cross terms shifted into the upper half.
  typedef enum logic [2:0] {
    ALU_ADD    = 3'd0,
    ALU_SUB    = 3'd1,
    ALU_MUL_LL = 3'd2,
    ALU_MUL_HL = 3'd3,
    ALU_MUL_LH = 3'd4
  } alu_op_t;

  typedef struct packed {
    logic    en;
    alu_op_t op;
  } alu_ctl_t;

endpackage

`default_nettype wire

@@ hdl/max_value_parenthesized_expression_unit.sv @@
// Top level of the parenthesized-expression maximum block: token store, sequencer
// for the interval program, and the result register.
// Depends on mvpe_pkg, mvpe_alu and mvpe_span_ram.
//
//   Channel   Direction  Handshake                    Payload
//   token     in         token_valid / token_ready    mvpe_pkg::token_t
//   result    out        result_valid / result_ready  mvpe_pkg::result_t
//
// A token is taken whenever the load state sees token_valid. After the last token
// the sequencer fills the diagonal one digit at a time, then for every split
// point spends a read state plus, per min/max pairing, an operate and a compare
// state, with three passes through the 32x32 multiplier for multiply; it writes
// once per span and reads out the answer; for 16 digits that is 680 split points.
// token_ready is low during this work. The result register lets the next
// expression load while a result waits; a finished expression stalls only if the
// previous result is still untaken. Reset is synchronous and clears the token
// count and flags; the span memory needs no clearing since every entry read was
// written first.
`default_nettype none

module max_value_parenthesized_expression_unit #(
  parameter int MAX_DIGITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                token_valid,
  output logic                     token_ready,
  input  wire mvpe_pkg::token_t    token,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output mvpe_pkg::result_t        result
);

  localparam int IW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int NW = CW + 1;
  localparam int AW = 2 * IW;
  localparam int VW = mvpe_pkg::VALUE_W;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_DIAG  = 9'b000000010,
    S_ADDR  = 9'b000000100,
    S_OPER  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_RES   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t                       state;
  logic [CW-1:0]                count;
  logic                         overflow;
  logic [IW-1:0]                i;
  logic [IW-1:0]                k;
  logic [IW-1:0]                len;
  logic [1:0]                   cidx;
  logic                         mphase;
  logic                         first;
  logic signed [VW-1:0]         lo;
  logic signed [VW-1:0]         hi;
  logic [mvpe_pkg::DIGIT_W-1:0] dig_mem [MAX_DIGITS];
  logic [mvpe_pkg::OP_W-1:0]    op_mem  [MAX_DIGITS];

  logic [IW-1:0]                j;
  logic [IW-1:0]                kp1;
  logic [CW-1:0]                cnt_m1;
  logic [mvpe_pkg::DIGIT_W-1:0] cur_digit;
  logic [mvpe_pkg::OP_W-1:0]    cur_op;
  logic [VW-1:0]                dext;
  logic                         diag_done;
  logic                         k_last;
  logic                         is_mul;
  logic                         is_sub;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [mvpe_pkg::SPAN_W-1:0]  wdata;
  logic [AW-1:0]                raddr_a;
  logic [AW-1:0]                raddr_b;
  logic [mvpe_pkg::SPAN_W-1:0]  rdata_a;
  logic [mvpe_pkg::SPAN_W-1:0]  rdata_b;

  mvpe_pkg::alu_ctl_t           alu_ctl;
  logic [VW-1:0]                alu_x;
  logic [VW-1:0]                alu_y;
  logic [VW-1:0]                alu_acc;
  logic signed [VW-1:0]         cand;

  // Span indices and loop-end tests.
  always_comb begin
    j         = i + len;
    kp1       = k + 1'b1;
    cnt_m1    = count - 1'b1;
    cur_digit = dig_mem[i];
    cur_op    = op_mem[k];
    dext      = {{(VW - mvpe_pkg::DIGIT_W){1'b0}}, cur_digit};
    diag_done = (NW'(i) + NW'(1)) == NW'(count);
    k_last    = (NW'(k) + NW'(1)) == NW'(j);
    is_mul    = (cur_op == mvpe_pkg::OP_MUL);
    is_sub    = (cur_op == mvpe_pkg::OP_SUB);
  end

  // Span memory ports: the left part is read on port a, the right part on port b.
  // The answer's address is held on port a for as long as the final state waits.
  always_comb begin
    we      = (state == S_DIAG) || (state == S_WRITE);
    waddr   = (state == S_DIAG) ? {i, i} : {i, j};
    wdata   = (state == S_DIAG) ? {dext, dext} : {lo, hi};
    raddr_a = ((state == S_RES) || (state == S_FIN)) ? {{IW{1'b0}}, cnt_m1[IW-1:0]}
                                                     : {i, k};
    raddr_b = {kp1, j};
  end

  mvpe_span_ram #(
    .AW (AW),
    .DW (mvpe_pkg::SPAN_W)
  ) u_span_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Candidate operands: the high bit of cidx picks the left max, the low bit the right max.
  always_comb begin
    alu_x      = cidx[1] ? rdata_a[VW-1:0] : rdata_a[2*VW-1:VW];
    alu_y      = cidx[0] ? rdata_b[VW-1:0] : rdata_b[2*VW-1:VW];
    alu_ctl.en = (state == S_OPER) || (state == S_MUL);
    if (state == S_MUL) begin
      alu_ctl.op = mphase ? mvpe_pkg::ALU_MUL_LH : mvpe_pkg::ALU_MUL_HL;
    end else if (is_mul) begin
      alu_ctl.op = mvpe_pkg::ALU_MUL_LL;
    end else if (is_sub) begin
      alu_ctl.op = mvpe_pkg::ALU_SUB;
    end else begin
      alu_ctl.op = mvpe_pkg::ALU_ADD;
    end
  end

  mvpe_alu u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .x   (alu_x),
    .y   (alu_y),
    .acc (alu_acc)
  );

  assign cand        = $signed(alu_acc);
  assign token_ready = (state == S_LOAD);

  // Sequencer: loads tokens, then walks span length, start and split point.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
      i            <= '0;
      k            <= '0;
      len          <= '0;
      cidx         <= '0;
      mphase       <= 1'b0;
      first        <= 1'b0;
    end else begin
      // The result register empties on a transfer; the final state refills it itself.
      if (result_valid && result_ready && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (token_valid) begin
            // Tokens past capacity are dropped and remembered.
            if (NW'(count) < NW'(MAX_DIGITS)) begin
              dig_mem[count[IW-1:0]] <= token.digit;
              op_mem[count[IW-1:0]]  <= token.op_after;
              count                  <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (token.last) begin
              i     <= '0;
              state <= S_DIAG;
            end
          end
        end

        S_DIAG: begin
          // Single-digit spans hold the digit as both minimum and maximum.
          if (diag_done) begin
            len   <= IW'(1);
            i     <= '0;
            k     <= '0;
            cidx  <= '0;
            first <= 1'b1;
            state <= (count == CW'(1)) ? S_RES : S_ADDR;
          end else begin
            i <= i + 1'b1;
          end
        end

        S_ADDR: begin
          state <= S_OPER;
        end

        S_OPER: begin
          if (is_mul) begin
            mphase <= 1'b0;
            state  <= S_MUL;
          end else begin
            state <= S_CMP;
          end
        end

        S_MUL: begin
          if (mphase) begin
            state <= S_CMP;
          end else begin
            mphase <= 1'b1;
          end
        end

        S_CMP: begin
          // The first candidate of a span seeds both bounds.
          if (first || (cand < lo)) begin
            lo <= cand;
          end
          if (first || (cand > hi)) begin
            hi <= cand;
          end
          first <= 1'b0;
          cidx  <= cidx + 1'b1;
          if (cidx == 2'd3) begin
            if (k_last) begin
              state <= S_WRITE;
            end else begin
              k     <= kp1;
              state <= S_ADDR;
            end
          end else begin
            state <= S_OPER;
          end
        end

        S_WRITE: begin
          // Next span of the same length, else the first span of the next length.
          first <= 1'b1;
          cidx  <= '0;
          if ((NW'(i) + NW'(len) + NW'(2)) <= NW'(count)) begin
            i     <= i + 1'b1;
            k     <= i + 1'b1;
            state <= S_ADDR;
          end else if ((NW'(len) + NW'(2)) <= NW'(count)) begin
            len   <= len + 1'b1;
            i     <= '0;
            k     <= '0;
            state <= S_ADDR;
          end else begin
            state <= S_RES;
          end
        end

        S_RES: begin
          state <= S_FIN;
        end

        S_FIN: begin
          // Hand the answer to the result register once it is free.
          if (!result_valid || result_ready) begin
            result.max_value <= $signed(rdata_a[mvpe_pkg::RES_W-1:0]);
            result.too_long  <= overflow;
            result_valid     <= 1'b1;
            count            <= '0;
            overflow         <= 1'b0;
            state            <= S_LOAD;
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // The token count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    NW'(count) <= NW'(MAX_DIGITS))
    else $error("token count above capacity");

  // Every split point lies inside its span.
  a_split_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ((k >= i) && (NW'(k) < NW'(j))))
    else $error("split point outside span");

  // Multiply cross terms follow the low-by-low step or each other.
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state == S_OPER) || $past(state == S_MUL)))
    else $error("multiply step out of order");

  // Returning to load after a result leaves a clean token count.
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_FIN) && (state == S_LOAD)) |-> ((count == '0) && !overflow))
    else $error("count or overflow not cleared after result");

  // A result appears only out of the final state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN))
    else $error("result raised outside final state");

endmodule

`default_nettype wire

@@ hdl/mvpe_span_ram.sv @@
// Span table memory: one write port and two registered read ports.
// Depends on nothing; the word layout is set by the instantiating module.
`default_nettype none

module mvpe_span_ram #(
  parameter int AW = 8,
  parameter int DW = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  output logic      [DW-1:0] rdata_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  // Write and both reads happen on the clock edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ hdl/mvpe_alu.sv @@
// Shared arithmetic unit: one 64-bit adder and one 32x32 multiplier with an accumulator.
// Depends on mvpe_pkg for the operation codes and widths.
`default_nettype none

module mvpe_alu (
  input  wire logic                           clk,
  input  wire mvpe_pkg::alu_ctl_t             ctl,
  input  wire logic [mvpe_pkg::VALUE_W-1:0]   x,
  input  wire logic [mvpe_pkg::VALUE_W-1:0]   y,
  output logic      [mvpe_pkg::VALUE_W-1:0]   acc
);

  logic [mvpe_pkg::HALF_W-1:0]  ma;
  logic [mvpe_pkg::HALF_W-1:0]  mb;
  logic [mvpe_pkg::VALUE_W-1:0] prod;
  logic [mvpe_pkg::VALUE_W-1:0] base;
  logic [mvpe_pkg::VALUE_W-1:0] addend;
  logic                         cin;
  logic [mvpe_pkg::VALUE_W-1:0] sum;

  // Pick the operand halves for the single multiplier.
  always_comb begin
    ma   = (ctl.op == mvpe_pkg::ALU_MUL_HL) ? x[mvpe_pkg::VALUE_W-1:mvpe_pkg::HALF_W]
                                            : x[mvpe_pkg::HALF_W-1:0];
    mb   = (ctl.op == mvpe_pkg::ALU_MUL_LH) ? y[mvpe_pkg::VALUE_W-1:mvpe_pkg::HALF_W]
                                            : y[mvpe_pkg::HALF_W-1:0];
    prod = ma * mb;
  end

  // Select what the adder sums. Only the low 64 bits of a product are kept,
  // which is exact because every product fits in a signed 64-bit value.
  always_comb begin
    case (ctl.op)
      mvpe_pkg::ALU_ADD: begin
        base   = x;
        addend = y;
        cin    = 1'b0;
      end
      mvpe_pkg::ALU_SUB: begin
        base   = x;
        addend = ~y;
        cin    = 1'b1;
      end
      mvpe_pkg::ALU_MUL_LL: begin
        base   = '0;
        addend = prod;
        cin    = 1'b0;
      end
      mvpe_pkg::ALU_MUL_HL, mvpe_pkg::ALU_MUL_LH: begin
        base   = acc;
        addend = {prod[mvpe_pkg::HALF_W-1:0], {mvpe_pkg::HALF_W{1'b0}}};
        cin    = 1'b0;
      end
      default: begin
        base   = x;
        addend = y;
        cin    = 1'b0;
      end
    endcase
    sum = base + addend + {{(mvpe_pkg::VALUE_W-1){1'b0}}, cin};
  end

  // The accumulator holds the latest result until the next enabled step.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= sum;
    end
  end

endmodule

`default_nettype wire
